// ----- rtl/bgl_pkg.sv -----
// ----------------------------------------------------------------------------
// bgl_pkg: shared types and constants for the bilinear grid lookup
// Field widths, register map codes, fixed-point constants and the control
// bundle that travels from address generation into the blend datapath.
// ----------------------------------------------------------------------------
package bgl_pkg;

  // default number of control points per grid side the store is sized for
  localparam int GRID_MAX_DEF = 32;

  // item fields
  localparam int COORD_W = 17;   // unsigned 1.16
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 24;   // signed Q7.16
  localparam int FRAC_W  = 17;   // 0..65536
  localparam int WGT_W   = 33;   // 0..2^32, product of two fractions

  localparam logic [COORD_W-1:0] ONE_Q16 = 17'd65536;

  // configuration register map (word index from paddr[2])
  localparam int GSIZE_W = 6;
  localparam logic REG_GRID_SIZE = 1'b0;
  localparam logic [GSIZE_W-1:0] GRID_SIZE_RST = 6'd2;

  typedef logic [WGT_W-1:0] weight_t;
  typedef logic signed [VALUE_W-1:0] point_t;

  // one evaluate item at the memory read stage, with its corner weights
  typedef struct packed {
    logic    valid;
    weight_t w11;
    weight_t w21;
    weight_t w12;
    weight_t w22;
  } blend_req_t;

endpackage

// ----- rtl/bgl_mem.sv -----
// ----------------------------------------------------------------------------
// bgl_mem: control point store
// Synchronous memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bgl_mem
  import bgl_pkg::*;
#(
  parameter int DEPTH  = GRID_MAX_DEF * GRID_MAX_DEF,
  parameter int ADDR_W = $clog2(GRID_MAX_DEF * GRID_MAX_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  point_t            wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output point_t            rdata_a,
  output point_t            rdata_b
);

  point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/bgl_addr.sv -----
// ----------------------------------------------------------------------------
// bgl_addr: coordinate split and address generation
// Scale both axes, split into cell and fraction, form the four corner
// addresses and weights, and carry write items to the memory stage.
// ----------------------------------------------------------------------------
module bgl_addr
  import bgl_pkg::*;
#(
  parameter int GRID_MAX = GRID_MAX_DEF,
  parameter int G_W      = $clog2(GRID_MAX_DEF + 1),
  parameter int ADDR_W   = $clog2(GRID_MAX_DEF * GRID_MAX_DEF)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               action,
  input  logic [COORD_W-1:0] x_coord,
  input  logic [COORD_W-1:0] y_coord,
  input  logic [INDEX_W-1:0] entry_index,
  input  point_t             entry_value,
  input  logic [G_W-1:0]     g,
  output logic               we,
  output logic [ADDR_W-1:0]  waddr,
  output point_t             wdata,
  output logic [ADDR_W-1:0]  addr11,
  output logic [ADDR_W-1:0]  addr21,
  output logic [ADDR_W-1:0]  addr12,
  output logic [ADDR_W-1:0]  addr22,
  output blend_req_t         req
);

  localparam int SC_W  = COORD_W + G_W;
  localparam int DEPTH = GRID_MAX * GRID_MAX;

  // stage 0: clamp and scale
  logic [COORD_W-1:0] cx, cy;
  logic [G_W-1:0]     gm1, gm2;
  logic [SC_W-1:0]    scx_in, scy_in;
  logic               wr_ok_in;

  assign gm1    = g - G_W'(1);
  assign gm2    = g - G_W'(2);
  assign cx     = (x_coord > ONE_Q16) ? ONE_Q16 : x_coord;
  assign cy     = (y_coord > ONE_Q16) ? ONE_Q16 : y_coord;
  assign scx_in = SC_W'(cx) * SC_W'(gm1);
  assign scy_in = SC_W'(cy) * SC_W'(gm1);
  assign wr_ok_in = action && (32'(entry_index) < 32'(DEPTH));

  // stage 1 registers
  logic              s1_eval, s1_wr;
  logic [SC_W-1:0]   s1_scx, s1_scy;
  logic [ADDR_W-1:0] s1_waddr;
  point_t            s1_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_eval <= 1'b0;
      s1_wr   <= 1'b0;
    end else begin
      s1_eval <= accept && !action;
      s1_wr   <= accept && wr_ok_in;
    end
  end

  always_ff @(posedge clk) begin
    s1_scx   <= scx_in;
    s1_scy   <= scy_in;
    s1_waddr <= ADDR_W'(entry_index);
    s1_wdata <= entry_value;
  end

  // stage 1: integer part clamped to g-2, remainder is the fraction
  logic [G_W:0]       bx_raw, by_raw;
  logic [G_W-1:0]     bx, by;
  logic [SC_W-1:0]    fx_full, fy_full;

  assign bx_raw  = s1_scx[SC_W-1:16];
  assign by_raw  = s1_scy[SC_W-1:16];
  assign bx      = (bx_raw > (G_W+1)'(gm2)) ? gm2 : bx_raw[G_W-1:0];
  assign by      = (by_raw > (G_W+1)'(gm2)) ? gm2 : by_raw[G_W-1:0];
  assign fx_full = s1_scx - (SC_W'(bx) << 16);
  assign fy_full = s1_scy - (SC_W'(by) << 16);

  // stage 2 registers
  logic              s2_eval, s2_wr;
  logic [G_W-1:0]    s2_bx, s2_by;
  logic [FRAC_W-1:0] s2_fx, s2_fy;
  logic [ADDR_W-1:0] s2_waddr;
  point_t            s2_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_eval <= 1'b0;
      s2_wr   <= 1'b0;
    end else begin
      s2_eval <= s1_eval;
      s2_wr   <= s1_wr;
    end
  end

  always_ff @(posedge clk) begin
    s2_bx    <= bx;
    s2_by    <= by;
    s2_fx    <= fx_full[FRAC_W-1:0];
    s2_fy    <= fy_full[FRAC_W-1:0];
    s2_waddr <= s1_waddr;
    s2_wdata <= s1_wdata;
  end

  // stage 2: corner addresses and weights; writes land here too, so item
  // order against the reads is kept without forwarding
  logic [2*G_W-1:0]   row_off;
  logic [2*G_W:0]     base, base_r, base_d, base_rd;
  logic [FRAC_W-1:0]  gx, gy;
  logic [2*FRAC_W-1:0] p_gg, p_fg, p_gf, p_ff;

  assign row_off = s2_by * g;
  assign base    = (2*G_W+1)'(row_off) + (2*G_W+1)'(s2_bx);
  assign base_r  = base + (2*G_W+1)'(1);
  assign base_d  = base + (2*G_W+1)'(g);
  assign base_rd = base_d + (2*G_W+1)'(1);

  assign addr11 = base[ADDR_W-1:0];
  assign addr21 = base_r[ADDR_W-1:0];
  assign addr12 = base_d[ADDR_W-1:0];
  assign addr22 = base_rd[ADDR_W-1:0];

  assign we    = s2_wr;
  assign waddr = s2_waddr;
  assign wdata = s2_wdata;

  assign gx   = ONE_Q16 - s2_fx;
  assign gy   = ONE_Q16 - s2_fy;
  assign p_gg = gx * gy;
  assign p_fg = s2_fx * gy;
  assign p_gf = gx * s2_fy;
  assign p_ff = s2_fx * s2_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      req.valid <= s2_eval;
    end
    req.w11 <= p_gg[WGT_W-1:0];
    req.w21 <= p_fg[WGT_W-1:0];
    req.w12 <= p_gf[WGT_W-1:0];
    req.w22 <= p_ff[WGT_W-1:0];
  end

endmodule

// ----- rtl/bgl_blend.sv -----
// ----------------------------------------------------------------------------
// bgl_blend: weighted corner blend
// Multiply corners by weights, sum in two steps, round to 1.16 and clamp.
// ----------------------------------------------------------------------------
module bgl_blend
  import bgl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  blend_req_t         req,
  input  point_t             p11,
  input  point_t             p21,
  input  point_t             p12,
  input  point_t             p22,
  output logic               done,
  output logic [COORD_W-1:0] z_value,
  output logic               was_clamped
);

  localparam int PROD_W = VALUE_W + WGT_W + 1;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PAIR_W + 1;
  localparam int ZF_W   = SUM_W - 32;

  // stage 3: products
  logic signed [PROD_W-1:0] m11_in, m21_in, m12_in, m22_in;
  logic [PROD_W-1:0]        m11, m21, m12, m22;
  logic                     s3_valid;

  assign m11_in = p11 * $signed({1'b0, req.w11});
  assign m21_in = p21 * $signed({1'b0, req.w21});
  assign m12_in = p12 * $signed({1'b0, req.w12});
  assign m22_in = p22 * $signed({1'b0, req.w22});

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    m11 <= m11_in;
    m21 <= m21_in;
    m12 <= m12_in;
    m22 <= m22_in;
  end

  // stage 4: pair sums
  logic [PAIR_W-1:0] pa, pb;
  logic              s4_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    pa <= {m11[PROD_W-1], m11} + {m21[PROD_W-1], m21};
    pb <= {m12[PROD_W-1], m12} + {m22[PROD_W-1], m22};
  end

  // stage 5: total, round half up, clamp to [0,1]
  logic [SUM_W-1:0]   total, rnd;
  logic [ZF_W-1:0]    z_full;
  logic [COORD_W-1:0] z_next;
  logic               positive;

  assign total    = {pa[PAIR_W-1], pa} + {pb[PAIR_W-1], pb};
  assign positive = !total[SUM_W-1] && (total != '0);
  assign rnd      = total + (SUM_W'(1) << 31);
  assign z_full   = rnd[SUM_W-1:32];

  always_comb begin
    if (!positive) begin
      z_next = '0;
    end else if (z_full > ZF_W'(ONE_Q16)) begin
      z_next = ONE_Q16;
    end else begin
      z_next = z_full[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    z_value     <= z_next;
    was_clamped <= (z_next == '0) || (z_next == ONE_Q16);
  end

endmodule

// ----- rtl/bilinear_grid_lookup_top.sv -----
// ----------------------------------------------------------------------------
// bilinear_grid_lookup_top: bilinear lookup over a square control point grid
// Loads signed Q7.16 control points and blends four neighbors per point.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle and never raises busy, so start
// may be held high continuously. A write item (action 1) stores entry_value
// at entry_index and gives no result; an index beyond the store is dropped.
// An evaluate item (action 0) gives exactly one result: done pulses for one
// cycle with z_value and was_clamped. The receiver cannot stall the block
// and must take each result in the cycle it is shown. Results appear in
// item order. The pipeline steps are: scale, split, address and weight
// forming, memory read, corner multiply, pair sums, and a final sum with
// rounding. The grid is held in two identical copies of a GRID_MAX*GRID_MAX
// memory, each with two read ports, so all four corners are read in the same
// cycle; writes update both copies at the read stage, so a write is seen by
// every later evaluate item and by no earlier one. Entries have no reset:
// read only written entries.
// grid_size (register 0, byte address 0) must be written over the APB port
// only while no evaluate item is in flight; the block does not enforce this.
// Values below 2 act as 2 and values above GRID_MAX act as GRID_MAX.
// ----------------------------------------------------------------------------
module bilinear_grid_lookup_top
  import bgl_pkg::*;
#(
  parameter int GRID_MAX = GRID_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [COORD_W-1:0] x_coord,
  input  logic [COORD_W-1:0] y_coord,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic signed [VALUE_W-1:0] entry_value,
  // result channel
  output logic               done,
  output logic [COORD_W-1:0] z_value,
  output logic               was_clamped,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int G_W    = $clog2(GRID_MAX + 1);
  localparam int DEPTH  = GRID_MAX * GRID_MAX;
  localparam int ADDR_W = $clog2(GRID_MAX * GRID_MAX);

  // configuration register: word index in paddr[2], byte offset ignored
  logic [GSIZE_W-1:0] grid_size;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_SIZE_RST;
    end else if (cfg_wr && (paddr[2] == REG_GRID_SIZE)) begin
      grid_size <= pwdata[GSIZE_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GRID_SIZE: prdata = 32'(grid_size);
      default:       prdata = '0;
    endcase
  end

  // effective grid size, held inside 2..GRID_MAX
  logic [G_W-1:0] g;

  always_comb begin
    if (grid_size < GSIZE_W'(2)) begin
      g = G_W'(2);
    end else if (32'(grid_size) > 32'(GRID_MAX)) begin
      g = G_W'(GRID_MAX);
    end else begin
      g = G_W'(grid_size);
    end
  end

  // fully pipelined: never hold off a start
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // address generation and write carry
  logic              we;
  logic [ADDR_W-1:0] waddr;
  point_t            wdata;
  logic [ADDR_W-1:0] addr11, addr21, addr12, addr22;
  blend_req_t        req;

  bgl_addr #(
    .GRID_MAX (GRID_MAX),
    .G_W      (G_W),
    .ADDR_W   (ADDR_W)
  ) u_addr (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .action      (action),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .g           (g),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata),
    .addr11      (addr11),
    .addr21      (addr21),
    .addr12      (addr12),
    .addr22      (addr22),
    .req         (req)
  );

  // two copies of the grid: upper row pair and lower row pair of the cell
  point_t p11, p21, p12, p22;

  bgl_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem_top (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (addr11),
    .raddr_b (addr21),
    .rdata_a (p11),
    .rdata_b (p21)
  );

  bgl_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem_bot (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (addr12),
    .raddr_b (addr22),
    .rdata_a (p12),
    .rdata_b (p22)
  );

  // blend, round and clamp
  bgl_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .p11         (p11),
    .p21         (p21),
    .p12         (p12),
    .p22         (p22),
    .done        (done),
    .z_value     (z_value),
    .was_clamped (was_clamped)
  );

endmodule

// ----- tb/tb_bilinear_grid_lookup_top.sv -----
// ----------------------------------------------------------------------------
// tb_bilinear_grid_lookup_top: self-checking bench for the bilinear grid lookup
// Loads control points, sweeps the grid size over the APB port and checks
// every interpolated point against an in-bench bilinear blend of the same
// table, with random start gaps and random item mixes.
// ----------------------------------------------------------------------------
module tb_bilinear_grid_lookup_top
  import bgl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STORE_DEPTH   = GRID_MAX_DEF * GRID_MAX_DEF;
  localparam int          SETTLE_CYCLES = 12;      // pipeline is six deep
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          PHASE_ITEMS   = 70;
  localparam longint      UNIT          = 65536;   // 1.0 in 1.16

  localparam logic        ACT_EVAL      = 1'b0;
  localparam logic        ACT_WRITE     = 1'b1;
  localparam logic [2:0]  ADDR_GRID_SIZE = {REG_GRID_SIZE, 2'b00};
  localparam logic [2:0]  ADDR_UNMAPPED  = 3'b100;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic               clamped;
  } lookup_t;

  // Tracks the control point table and grid size, blends each accepted
  // evaluate transfer into an expected lookup and checks results in order.
  class lookup_tracker;
    point_t               grid_points [STORE_DEPTH];
    logic [GSIZE_W-1:0]   grid_size;
    lookup_t              awaited_lookups [$];
    int                   mismatch_count;

    function new();
      grid_size      = GRID_SIZE_RST;
      mismatch_count = 0;
    endfunction

    function int unsigned active_grid();
      if (grid_size < 2)
        return 2;
      if (grid_size > GRID_MAX_DEF)
        return GRID_MAX_DEF;
      return grid_size;
    endfunction

    function void split_axis(input logic [COORD_W-1:0] coord, input int unsigned g,
                             output int unsigned seg, output int unsigned frac);
      int unsigned c;
      int unsigned scaled;
      c = coord;
      if (c > UNIT)
        c = UNIT;
      scaled = c * (g - 1);
      seg = scaled >> 16;
      if (seg > g - 2)
        seg = g - 2;
      frac = scaled - (seg << 16);
    endfunction

    // Index of the top-left corner of the cell that holds (x,y).
    function void locate_cell(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              output int unsigned base, output int unsigned g);
      int unsigned cx, fx, cy, fy;
      g = active_grid();
      split_axis(x, g, cx, fx);
      split_axis(y, g, cy, fy);
      base = cx + cy * g;
    endfunction

    function lookup_t blend_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      int unsigned g, cx, fx, cy, fy, base;
      longint      p11, p21, p12, p22, gx, gy, sum, zr;
      lookup_t     res;
      g = active_grid();
      split_axis(x, g, cx, fx);
      split_axis(y, g, cy, fy);
      base = cx + cy * g;
      p11 = grid_points[base];
      p21 = grid_points[base + 1];
      p12 = grid_points[base + g];
      p22 = grid_points[base + g + 1];
      gx  = UNIT - longint'(fx);
      gy  = UNIT - longint'(fy);
      // exact sum with 48 fraction bits
      sum = p11 * (gx * gy) + p21 * (longint'(fx) * gy)
          + p12 * (gx * longint'(fy)) + p22 * (longint'(fx) * longint'(fy));
      if (sum <= 0) begin
        zr = 0;
      end else begin
        zr = (sum + 64'sd2147483648) >>> 32;   // round half up to 16 bits
        if (zr > UNIT)
          zr = UNIT;
      end
      res.z       = zr[COORD_W-1:0];
      res.clamped = (zr == 0) || (zr == UNIT);
      return res;
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task note_transfer(logic act, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                       logic [INDEX_W-1:0] idx, point_t val);
      if (act == ACT_WRITE) begin
        if (idx < STORE_DEPTH)
          grid_points[idx] = val;
      end else begin
        awaited_lookups.push_back(blend_point(x, y));
      end
    endtask

    task check_result(logic [COORD_W-1:0] z, logic clamped);
      lookup_t want;
      if (awaited_lookups.size() == 0) begin
        report_mismatch($sformatf("result z_value=%0d with no lookup pending", z));
        return;
      end
      want = awaited_lookups.pop_front();
      if (z !== want.z)
        report_mismatch($sformatf("z_value %0d, expected %0d", z, want.z));
      if (clamped !== want.clamped)
        report_mismatch($sformatf("was_clamped %0b, expected %0b (z_value %0d)",
                                  clamped, want.clamped, want.z));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic               busy;
  logic               action      = ACT_EVAL;
  logic [COORD_W-1:0] x_coord     = '0;
  logic [COORD_W-1:0] y_coord     = '0;
  logic [INDEX_W-1:0] entry_index = '0;
  point_t             entry_value = '0;
  logic               done;
  logic [COORD_W-1:0] z_value;
  logic               was_clamped;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [2:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  lookup_tracker      lookups = new();
  bit                 point_loaded [STORE_DEPTH];   // entries the table holds
  bit                 gaps_on = 1'b1;
  int                 cycle_count = 0;

  bilinear_grid_lookup_top uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .done        (done),
    .z_value     (z_value),
    .was_clamped (was_clamped),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case a transfer or a result never shows up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: done is a one-cycle strobe, sampled at the edge ending it.
  always @(posedge clk) begin
    if (!rst && done)
      lookups.check_result(z_value, was_clamped);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Coordinates: mostly inside [0,1], with exact bounds and values above one
  // (bit 16 set together with low bits) mixed in.
  function automatic logic [COORD_W-1:0] rand_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)
      return '0;
    if (r < 16)
      return ONE_Q16;
    if (r < 26)
      return COORD_W'($urandom_range(65537, 131071));
    return COORD_W'($urandom_range(0, 65536));
  endfunction

  // Control points: mostly near the unit range so blends land inside (0,1);
  // the rest small, exact bounds, or anywhere in the Q7.16 range.
  function automatic point_t rand_point();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 15)
      v = ($urandom_range(0, 1) == 1) ? 65536 : 0;
    else if (r < 60)
      v = int'($urandom_range(0, 73728)) - 4096;
    else if (r < 75)
      v = int'($urandom_range(0, 512)) - 256;
    else
      v = int'($urandom_range(0, 24'hFFFFFF));
    return point_t'(v);
  endfunction

  // Present one item and hold it until the start transfer; may insert a
  // random gap first. Returns at the accepting edge.
  task automatic issue_item(logic act, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [INDEX_W-1:0] idx, point_t val);
    if (gaps_on && $urandom_range(0, 99) < 24) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start       <= 1'b1;
    action      <= act;
    x_coord     <= x;
    y_coord     <= y;
    entry_index <= idx;
    entry_value <= val;
    do @(posedge clk); while (busy);
    lookups.note_transfer(act, x, y, idx, val);
    if (act == ACT_WRITE)
      point_loaded[idx] = 1'b1;
  endtask

  // Coordinates of a write are don't-care: randomize them.
  task automatic load_point(logic [INDEX_W-1:0] idx, point_t val);
    issue_item(ACT_WRITE, COORD_W'($urandom), COORD_W'($urandom), idx, val);
  endtask

  // Index and value of an evaluate are don't-care: randomize them.
  task automatic sample_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    issue_item(ACT_EVAL, x, y, INDEX_W'($urandom), point_t'($urandom));
  endtask

  // Drop start and hold until every pending lookup has come back.
  task automatic wait_lookups_drained();
    start <= 1'b0;
    do @(posedge clk); while (lookups.awaited_lookups.size() != 0);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Change the grid size with the pipeline empty, then read it back.
  task automatic set_grid_size(logic [GSIZE_W-1:0] value);
    logic [31:0] readback;
    wait_lookups_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);   // let trailing writes retire
    apb_access(1'b1, ADDR_GRID_SIZE, {{(32-GSIZE_W){1'b0}}, value}, readback);
    apb_access(1'b0, ADDR_GRID_SIZE, '0, readback);
    if (readback !== {{(32-GSIZE_W){1'b0}}, value})
      lookups.report_mismatch($sformatf("grid_size reads %0h after writing %0h",
                                        readback, value));
    lookups.grid_size = value;
  endtask

  // Random phase: mostly lookups whose four corners are loaded first where
  // needed, plus stray writes anywhere in the table.
  task automatic run_phase(int budget);
    int                 sent;
    int unsigned        base, g;
    int unsigned        corner [4];
    logic [COORD_W-1:0] x, y;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 20) begin
        g = lookups.active_grid();
        if ($urandom_range(0, 1) == 1)
          load_point(INDEX_W'($urandom_range(0, STORE_DEPTH - 1)), rand_point());
        else
          load_point(INDEX_W'($urandom_range(0, g * g - 1)), rand_point());
        sent++;
      end else begin
        x = rand_coord();
        y = rand_coord();
        lookups.locate_cell(x, y, base, g);
        corner[0] = base;
        corner[1] = base + 1;
        corner[2] = base + g;
        corner[3] = base + g + 1;
        // never read an entry the table has not been given
        foreach (corner[k]) begin
          if (!point_loaded[corner[k]]) begin
            load_point(INDEX_W'(corner[k]), rand_point());
            sent++;
          end
        end
        sample_point(x, y);
        sent++;
      end
      if ($urandom_range(0, 199) == 0)
        wait_lookups_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [GSIZE_W-1:0] grid_plan [12];
    logic [31:0]        scratch;

    // sizes at both ends, out-of-range values that clamp, and some between
    grid_plan = '{6'd3, 6'd32, 6'd2, 6'd0, 6'd7, 6'd63, 6'd1, 6'd16, 6'd33, 6'd4,
                  6'd31, 6'd9};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset grid size of two, a single cell in entries 0..3.
    load_point(10'd0, 24'sd0);
    load_point(10'd1, 24'sd65536);
    load_point(10'd2, 24'sd65536);
    load_point(10'd3, 24'sh7FFFFF);               // largest point
    sample_point('0, '0);                         // lands on zero
    sample_point(ONE_Q16, '0);                    // lands on one
    sample_point(17'h1FFFF, 17'h1FFFF);           // both axes above one
    sample_point(17'd32768, 17'd32768);           // overshoots one
    load_point(10'd3, 24'sh800000);               // most negative point
    sample_point(ONE_Q16, ONE_Q16);               // corner at the far end
    sample_point(17'd32768, '0);                  // exactly one half
    sample_point(17'd1, '0);                      // smallest step
    load_point(10'd1, 24'sd1);
    sample_point(17'd32768, '0);                  // rounding tie goes up
    sample_point(17'd32767, '0);                  // just under the tie
    load_point(10'h3FF, 24'sh7ABCDE);             // top of the index range
    load_point(10'd0, 24'shFFFFFF);               // all value bits set
    sample_point('0, ONE_Q16);
    sample_point(17'd16384, 17'd49152);
    sample_point(17'd98304, '0);                  // above one with low bits

    // A write to an unmapped register must leave the grid size alone.
    wait_lookups_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_access(1'b1, ADDR_UNMAPPED, 32'hFFFF_FFFF, scratch);
    sample_point(17'd40000, 17'd20000);

    foreach (grid_plan[p]) begin
      set_grid_size(grid_plan[p]);
      gaps_on = (p != 3);                         // one long back-to-back stretch
      run_phase(PHASE_ITEMS);
    end

    wait_lookups_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);        // catch stray results

    if (lookups.mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bgl_pkg.sv
rtl/bgl_mem.sv
rtl/bgl_addr.sv
rtl/bgl_blend.sv
rtl/bilinear_grid_lookup_top.sv
tb/tb_bilinear_grid_lookup_top.sv
